/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the minimum-tracking stack.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, suspended while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the controller, datapath and top level of the
// minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 64;
  localparam int unsigned DEF_VALUE_WIDTH = 32;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_MIN  = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;     // capture request and read top entry
    logic    push_en;  // write entry, bump count
    logic    pop_en;   // drop entry, restore minimum
    logic    emit;     // register result of current transaction
    status_t code;     // status of current transaction
  } mts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    req_t op;
    logic empty;
    logic full;
  } mts_stat_t;

endpackage

/* rtl/min_tracking_stack.sv */
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded signed stack that reports its minimum at any time.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_type / push_value; a transaction is taken at a
//   rising edge where start is high and busy is low. req_type selects push,
//   pop, peek top or read minimum.
//   Each transaction gives one result on status / result_value, shown for
//   one cycle with done high. The receiver cannot hold results off.
// Timing:
//   The accepting edge captures the request and reads the top entry from
//   the synchronous store. busy is then high in the execute state, at whose
//   end the result is registered and done rises. No request is taken while
//   busy is high, so a new request is only taken once the last one has
//   given its result.
// Reset:
//   rst (synchronous) empties the stack and zeroes the minimum; store
//   contents are left as they are and are used only once written.
// Status:
//   empty on pop/peek/minimum of an empty stack, full on push to a full
//   stack; result_value is zero unless status is ok.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic signed [VALUE_WIDTH-1:0] push_value,
  output logic                          done,
  output logic [1:0]                    status,
  output logic signed [VALUE_WIDTH-1:0] result_value
);
  import mts_pkg::*;

  mts_cmd_t  cmd;
  mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  mts_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .push_value   (push_value),
    .status       (status),
    .result_value (result_value)
  );

endmodule

/* rtl/mts_ctrl.sv */
// ----------------------------------------------------------------------------
// mts_ctrl
// Two-state sequencer: captures a request, then executes it once the top
// entry has been read from the store.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  mts_pkg::mts_stat_t stat,
  output mts_pkg::mts_cmd_t  cmd
);
  import mts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) state <= S_EXEC;
        end
        S_EXEC: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state == S_EXEC);

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.code    = ST_OK;
    cmd.load    = (state == S_IDLE) && start;
    cmd.emit    = (state == S_EXEC);
    unique case (stat.op)
      REQ_PUSH: begin
        cmd.code    = stat.full ? ST_FULL : ST_OK;
        cmd.push_en = (state == S_EXEC) && !stat.full;
      end
      REQ_POP: begin
        cmd.code   = stat.empty ? ST_EMPTY : ST_OK;
        cmd.pop_en = (state == S_EXEC) && !stat.empty;
      end
      REQ_PEEK, REQ_MIN: begin
        cmd.code = stat.empty ? ST_EMPTY : ST_OK;
      end
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted request did not go busy")
  `ASSERT_CLK(a_done_idle, done |-> !busy && $past(busy), "result strobe out of sequence")
  `ASSERT_ALWAYS(a_push_pop_excl, !(cmd.push_en && cmd.pop_en), "push and pop together")

endmodule

/* rtl/mts_dp.sv */
// ----------------------------------------------------------------------------
// mts_dp
// Entry store, count, current minimum and the encode / decode arithmetic.
// ----------------------------------------------------------------------------
module mts_dp #(
  parameter int unsigned STACK_DEPTH = mts_pkg::DEF_STACK_DEPTH,
  parameter int unsigned VALUE_WIDTH = mts_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mts_pkg::mts_cmd_t             cmd,
  output mts_pkg::mts_stat_t            stat,
  input  logic [1:0]                    req_type,
  input  logic signed [VALUE_WIDTH-1:0] push_value,
  output logic [1:0]                    status,
  output logic signed [VALUE_WIDTH-1:0] result_value
);
  import mts_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = VALUE_WIDTH + 2;

  logic signed [EW-1:0]          mem [STACK_DEPTH];
  logic signed [EW-1:0]          top;
  logic [CW-1:0]                 count;
  logic signed [VALUE_WIDTH-1:0] cur_min;
  logic signed [VALUE_WIDTH-1:0] val_q;
  req_t                          op_q;

  logic signed [EW-1:0]          x_ext;
  logic signed [EW-1:0]          min_ext;
  logic signed [EW-1:0]          enc;
  logic signed [EW-1:0]          min_restore;
  logic                          below;
  logic                          encoded;
  logic signed [VALUE_WIDTH-1:0] top_val;
  logic signed [VALUE_WIDTH-1:0] res;
  logic [AW-1:0]                 rd_addr;

  assign rd_addr = AW'(count - CW'(1));

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= req_t'(req_type);
      val_q <= push_value;
    end
  end

  // Store: write on push, registered read of the top entry at capture
  always_ff @(posedge clk) begin
    if (cmd.push_en) mem[AW'(count)] <= enc;
    if (cmd.load)    top <= mem[rd_addr];
  end

  // Encode / decode arithmetic
  always_comb begin
    x_ext       = EW'(val_q);
    min_ext     = EW'(cur_min);
    below       = (x_ext < min_ext);
    encoded     = (top < min_ext);
    min_restore = {min_ext[EW-2:0], 1'b0} - top;
    top_val     = encoded ? cur_min : top[VALUE_WIDTH-1:0];
    if (stat.empty || !below) enc = x_ext;
    else                      enc = {x_ext[EW-2:0], 1'b0} - min_ext;
    case (op_q)
      REQ_PUSH:          res = val_q;
      REQ_POP, REQ_PEEK: res = top_val;
      default:           res = cur_min;
    endcase
  end

  // Count and minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cur_min <= '0;
    end else if (cmd.push_en) begin
      count <= count + CW'(1);
      if (stat.empty || below) cur_min <= val_q;
    end else if (cmd.pop_en) begin
      count <= count - CW'(1);
      if (encoded) cur_min <= min_restore[VALUE_WIDTH-1:0];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= cmd.code;
      result_value <= (cmd.code == ST_OK) ? res : '0;
    end
  end

  assign stat.op    = op_q;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(STACK_DEPTH));

  `include "assert_macros.svh"

  `ASSERT_CLK(a_count_range, count <= CW'(STACK_DEPTH), "entry count beyond depth")
  `ASSERT_CLK(a_pop_count, cmd.pop_en |=> count == $past(count) - CW'(1), "pop miscounted")
  `ASSERT_CLK(a_push_min, (cmd.push_en && below) |=> cur_min == $past(val_q),
              "minimum not taken on push")

endmodule

/* tb/sv/min_tracking_stack_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack_tb
// Self-checking bench for the minimum-tracking stack. A short directed table
// covers the empty and extreme cases and the encoded entries. A long random
// run follows, in phases that lean towards push or pop so that both the empty
// and the full stack are reached. Responses are compared with a behavioural
// model the bench keeps, or with the response typed into a fixed table row.
// ----------------------------------------------------------------------------
module min_tracking_stack_tb;

  import mts_pkg::*;

  localparam int unsigned DEPTH = DEF_STACK_DEPTH;
  localparam int unsigned VW    = DEF_VALUE_WIDTH;
  localparam int          RANDOM_ITEMS = 1850;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          REPORT_LIMIT = 10;

  localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct {
    status_t              st;
    logic signed [VW-1:0] val;
  } response_t;

  // One directed transaction; fixed rows carry their response typed in
  typedef struct {
    req_t                 op;
    logic signed [VW-1:0] val;
    bit                   fixed;
    status_t              st;
    logic signed [VW-1:0] res;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           req_type = REQ_PUSH;
  logic signed [VW-1:0] push_value = '0;
  logic                 busy;
  logic                 done;
  logic [1:0]           status;
  logic signed [VW-1:0] result_value;

  // Bench copy of the stack, in the same encoded form as the block keeps it
  longint      shadow_mem [DEPTH];
  int unsigned shadow_count = 0;
  longint      shadow_min = 0;

  response_t   pending_responses[$];
  response_t   oldest;
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;

  stim_row_t directed_rows[] = '{
    '{REQ_POP,  0,       1'b1, ST_EMPTY, 0},
    '{REQ_PEEK, VAL_MAX, 1'b1, ST_EMPTY, 0},
    '{REQ_MIN,  VAL_MIN, 1'b1, ST_EMPTY, 0},
    '{REQ_PUSH, 5,       1'b1, ST_OK,    5},
    '{REQ_PUSH, VAL_MAX, 1'b1, ST_OK,    VAL_MAX},
    '{REQ_PUSH, VAL_MIN, 1'b1, ST_OK,    VAL_MIN},
    '{REQ_MIN,  0,       1'b1, ST_OK,    VAL_MIN},
    '{REQ_PEEK, 0,       1'b0, ST_OK,    0},
    '{REQ_PUSH, VAL_MIN, 1'b1, ST_OK,    VAL_MIN},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_MIN,  0,       1'b0, ST_OK,    0},
    '{REQ_PEEK, 0,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_PUSH, 5,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_POP,  -1,      1'b1, ST_EMPTY, 0},
    '{REQ_MIN,  0,       1'b1, ST_EMPTY, 0},
    '{REQ_PUSH, 100,     1'b0, ST_OK,    0},
    '{REQ_MIN,  0,       1'b0, ST_OK,    0},
    '{REQ_PUSH, -1,      1'b0, ST_OK,    0},
    '{REQ_PEEK, 0,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0},
    '{REQ_POP,  0,       1'b0, ST_OK,    0}
  };

  min_tracking_stack dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .push_value   (push_value),
    .done         (done),
    .status       (status),
    .result_value (result_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Apply one transaction to the bench copy and return its response
  function automatic response_t stack_response(req_t op, logic signed [VW-1:0] val);
    response_t r;
    longint    x;
    longint    top;
    bit        encoded;
    x     = val;
    r.st  = ST_OK;
    r.val = '0;
    if (op == REQ_PUSH) begin
      if (shadow_count == DEPTH) begin
        r.st = ST_FULL;
      end else begin
        if (shadow_count == 0) begin
          shadow_min = x;
          shadow_mem[shadow_count] = x;
        end else if (x < shadow_min) begin
          // value below the minimum: store the encoded form
          shadow_mem[shadow_count] = 2 * x - shadow_min;
          shadow_min = x;
        end else begin
          shadow_mem[shadow_count] = x;
        end
        shadow_count++;
        r.val = val;
      end
    end else if (shadow_count == 0) begin
      r.st = ST_EMPTY;
    end else if (op == REQ_MIN) begin
      r.val = shadow_min[VW-1:0];
    end else begin
      top     = shadow_mem[shadow_count - 1];
      encoded = top < shadow_min;
      r.val   = encoded ? shadow_min[VW-1:0] : top[VW-1:0];
      if (op == REQ_POP) begin
        shadow_count--;
        if (encoded) shadow_min = 2 * shadow_min - top;
      end
    end
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Spread of push values: extremes, near ties with the minimum, small, wide
  function automatic logic signed [VW-1:0] pick_value();
    logic signed [VW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = '0;
          default: v = '1;
        endcase
      end
      1, 2: v = $signed($urandom_range(0, 16)) - 8;
      3: v = shadow_min[VW-1:0] + $signed($urandom_range(0, 4)) - 2;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Drive one transaction, wait for it to be taken, record its response
  task automatic issue(input req_t op, input logic signed [VW-1:0] val, input int gap,
                       input bit fixed, input status_t fst,
                       input logic signed [VW-1:0] fval);
    response_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= op;
    push_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = stack_response(op, val);
    if (fixed) begin
      r.st  = fst;
      r.val = fval;
    end
    pending_responses.push_back(r);
  endtask

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT)
      $display("ERROR: %s at %0t: expected %0d, got %0d", what, $realtime, want, got);
  endtask

  // Response checker and stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done) begin
        if (pending_responses.size() == 0) begin
          note_mismatch("unexpected response, status", -1, status);
        end else begin
          oldest = pending_responses.pop_front();
          if (status !== oldest.st) note_mismatch("status", oldest.st, status);
          if (result_value !== oldest.val)
            note_mismatch("result_value", oldest.val, result_value);
        end
      end
    end
  end

  // Stimulus
  initial begin
    int   sent;
    int   phase_len;
    int   push_pct;
    bit   no_gaps;
    int   r;
    req_t op;
    logic signed [VW-1:0] v;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i])
      issue(directed_rows[i].op, directed_rows[i].val, pick_gap(), directed_rows[i].fixed,
            directed_rows[i].st, directed_rows[i].res);

    // random phases, each leaning towards filling or draining the stack
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: push_pct = 15;
        1: push_pct = 50;
        2: push_pct = 85;
        default: push_pct = 97;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct) begin
          op = REQ_PUSH;
          v  = pick_value();
        end else begin
          r  = $urandom_range(0, 9);
          op = (r < 6) ? REQ_POP : (r < 8) ? REQ_PEEK : REQ_MIN;
          v  = $urandom;
        end
        issue(op, v, no_gaps ? 0 : pick_gap(), 1'b0, ST_OK, '0);
        sent++;
      end
    end
    start <= 1'b0;

    // drain outstanding responses, then let the clock run on with start low
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
